FILE: hw/rtl/hcls_pkg.sv
// Shared types and constants for the IPv4 L4 header classifier.
// Holds the verdict codes, the configuration register indexes and the result struct.
// No dependencies.
`default_nettype none

package hcls_pkg;

	localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// Byte offsets inside the frame.
	localparam logic [7:0] IP_START      = 8'd14;
	localparam logic [7:0] ADDR_END      = 8'd34;
	localparam logic [7:0] TCP_NEED      = 8'd14;
	localparam logic [7:0] UDP_NEED      = 8'd4;
	localparam logic [7:0] TCP_FLAGS_OFS = 8'd13;
	localparam logic [6:0] OFFSET_MAX    = 7'd127;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_VIRTUAL_ADDRESS = 2'd0,
		CFG_VIRTUAL_PORT    = 2'd1,
		CFG_OWN_ADDRESS     = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		VERDICT_DROP    = 2'd0,
		VERDICT_ARP     = 2'd1,
		VERDICT_FORWARD = 2'd2,
		VERDICT_REVERSE = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [31:0] virtual_address;
		logic [15:0] virtual_port;
		logic [31:0] own_address;
	} hcls_cfg_t;

	typedef struct packed {
		verdict_t    verdict;
		logic        meta_valid;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  protocol;
		logic [7:0]  tcp_flag_bits;
		logic [47:0] src_mac;
		logic        direction;
		logic        truncated;
	} hcls_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hcls_frame_parse.sv
// Per-frame header state and classification logic for the classifier.
// Updates the header fields one byte per step and forms the verdict for the last byte.
// Depends on hcls_pkg.
`default_nettype none

module hcls_frame_parse (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            byte_in,
	input  wire logic                  last_in,
	input  wire hcls_pkg::hcls_cfg_t   cfg,
	output hcls_pkg::hcls_result_t     result
);
	import hcls_pkg::*;

	logic [6:0]  offset_q;
	logic [15:0] ether_kind_q;
	logic [3:0]  header_words_q;
	logic [7:0]  proto_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [7:0]  flags_q;
	logic [47:0] mac_q;

	logic [15:0] ether_kind_n;
	logic [3:0]  header_words_n;
	logic [7:0]  proto_n;
	logic [31:0] src_addr_n;
	logic [31:0] dst_addr_n;
	logic [15:0] src_port_n;
	logic [15:0] dst_port_n;
	logic [7:0]  flags_n;
	logic [47:0] mac_n;
	logic [6:0]  offset_n;
	logic [7:0]  off;
	logic [7:0]  l4;
	logic [7:0]  need;
	logic [7:0]  len;
	logic        is_tcp;

	always_comb begin
		off = {1'b0, offset_q};
		len = off + 8'd1;

		header_words_n = header_words_q;
		if (off == IP_START) begin
			header_words_n = byte_in[3:0];
		end
		l4 = IP_START + {2'b00, header_words_n, 2'b00};

		mac_n = mac_q;
		if (off >= 8'd6 && off <= 8'd11) begin
			mac_n = {mac_q[39:0], byte_in};
		end
		ether_kind_n = ether_kind_q;
		if (off == 8'd12 || off == 8'd13) begin
			ether_kind_n = {ether_kind_q[7:0], byte_in};
		end
		proto_n = proto_q;
		if (off == 8'd23) begin
			proto_n = byte_in;
		end
		src_addr_n = src_addr_q;
		if (off >= 8'd26 && off <= 8'd29) begin
			src_addr_n = {src_addr_q[23:0], byte_in};
		end
		dst_addr_n = dst_addr_q;
		if (off >= 8'd30 && off <= 8'd33) begin
			dst_addr_n = {dst_addr_q[23:0], byte_in};
		end
		src_port_n = src_port_q;
		dst_port_n = dst_port_q;
		flags_n    = flags_q;
		if (off >= IP_START) begin
			if (off == l4 || off == l4 + 8'd1) begin
				src_port_n = {src_port_q[7:0], byte_in};
			end
			if (off == l4 + 8'd2 || off == l4 + 8'd3) begin
				dst_port_n = {dst_port_q[7:0], byte_in};
			end
			if (off == l4 + TCP_FLAGS_OFS) begin
				flags_n = byte_in;
			end
		end

		offset_n = (offset_q == OFFSET_MAX) ? offset_q : offset_q + 7'd1;

		is_tcp = (proto_n == PROTO_TCP);
		need = l4 + (is_tcp ? TCP_NEED : UDP_NEED);
		if (need < ADDR_END) begin
			need = ADDR_END;
		end

		result = '0;
		result.verdict = VERDICT_DROP;
		if (len < IP_START) begin
			result.truncated = 1'b1;
		end else if (ether_kind_n == ETHERTYPE_ARP) begin
			result.verdict = VERDICT_ARP;
		end else if (ether_kind_n != ETHERTYPE_IPV4) begin
			result.verdict = VERDICT_DROP;
		end else if (len < 8'd24) begin
			result.truncated = 1'b1;
		end else if (is_tcp || proto_n == PROTO_UDP) begin
			if (len < need) begin
				result.truncated = 1'b1;
			end else begin
				result.meta_valid    = 1'b1;
				result.source_ip     = src_addr_n;
				result.dest_ip       = dst_addr_n;
				result.source_port   = src_port_n;
				result.dest_port     = dst_port_n;
				result.protocol      = proto_n;
				result.tcp_flag_bits = is_tcp ? flags_n : 8'd0;
				result.src_mac       = mac_n;
				if (dst_addr_n == cfg.virtual_address && dst_port_n == cfg.virtual_port) begin
					result.verdict = VERDICT_FORWARD;
				end else if (dst_addr_n == cfg.own_address) begin
					result.verdict   = VERDICT_REVERSE;
					result.direction = 1'b1;
				end
			end
		end
	end

	// The whole frame state returns to zero after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q       <= '0;
			ether_kind_q   <= '0;
			header_words_q <= '0;
			proto_q        <= '0;
			src_addr_q     <= '0;
			dst_addr_q     <= '0;
			src_port_q     <= '0;
			dst_port_q     <= '0;
			flags_q        <= '0;
			mac_q          <= '0;
		end else if (step) begin
			if (last_in) begin
				offset_q       <= '0;
				ether_kind_q   <= '0;
				header_words_q <= '0;
				proto_q        <= '0;
				src_addr_q     <= '0;
				dst_addr_q     <= '0;
				src_port_q     <= '0;
				dst_port_q     <= '0;
				flags_q        <= '0;
				mac_q          <= '0;
			end else begin
				offset_q       <= offset_n;
				ether_kind_q   <= ether_kind_n;
				header_words_q <= header_words_n;
				proto_q        <= proto_n;
				src_addr_q     <= src_addr_n;
				dst_addr_q     <= dst_addr_n;
				src_port_q     <= src_port_n;
				dst_port_q     <= dst_port_n;
				flags_q        <= flags_n;
				mac_q          <= mac_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_offset_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> offset_q == '0 && ether_kind_q == '0)
		else $error("frame state not cleared after last byte");
	a_offset_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_in && offset_q == OFFSET_MAX |=> offset_q == OFFSET_MAX)
		else $error("byte offset wrapped");
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(offset_q) && $stable(dst_addr_q))
		else $error("frame state changed without a byte");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_l4_header_classifier.sv
// Top level of the IPv4 L4 header classifier: handshake, configuration and result register.
// Depends on hcls_pkg and hcls_frame_parse.
//
// Usage: an Ethernet frame enters one byte per transaction on the input channel
// (in_valid, in_stall, frame_byte, last_byte), in wire order, last_byte high on the
// final byte. Each frame yields exactly one result transaction on the output channel
// (out_valid, out_stall and the result fields), carrying the verdict, the extracted
// IPv4/TCP/UDP fields and the truncation flag.
// A last byte passes the input register, then the result register. Throughput is one byte
// per cycle while in_stall is low, limited only by the single input register and the
// one-deep result register. When the receiver stalls, the result is held; non-final
// bytes keep flowing, and the input stalls only when a final byte waits in the input
// register behind a held result. The user must write the configuration port (cfg_write,
// cfg_index, cfg_data) only while no frame is in flight; the block does not enforce it.
// Reset clears the configuration registers, the frame state and both valids.
`default_nettype none

module ipv4_l4_header_classifier (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       frame_byte,
	input  wire logic                             last_byte,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            verdict,
	output logic                                  meta_valid,
	output logic [31:0]                           source_ip,
	output logic [31:0]                           dest_ip,
	output logic [15:0]                           source_port,
	output logic [15:0]                           dest_port,
	output logic [7:0]                            protocol,
	output logic [7:0]                            tcp_flag_bits,
	output logic [47:0]                           src_mac,
	output logic                                  direction,
	output logic                                  truncated,
	input  wire logic                             cfg_write,
	input  wire logic [hcls_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [hcls_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hcls_pkg::*;

	hcls_cfg_t    cfg_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         s1_move;
	logic         step;
	logic         accept;
	logic         out_valid_q;
	hcls_result_t result;
	hcls_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_VIRTUAL_ADDRESS: cfg_q.virtual_address <= cfg_data;
				CFG_VIRTUAL_PORT:    cfg_q.virtual_port    <= cfg_data[15:0];
				CFG_OWN_ADDRESS:     cfg_q.own_address     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A final byte can leave the input register only when the result register is free.
	assign s1_move  = !last_s1 || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	hcls_frame_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = res_q.verdict;
	assign meta_valid    = res_q.meta_valid;
	assign source_ip     = res_q.source_ip;
	assign dest_ip       = res_q.dest_ip;
	assign source_port   = res_q.source_port;
	assign dest_port     = res_q.dest_port;
	assign protocol      = res_q.protocol;
	assign tcp_flag_bits = res_q.tcp_flag_bits;
	assign src_mac       = res_q.src_mac;
	assign direction     = res_q.direction;
	assign truncated     = res_q.truncated;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && out_stall |-> in_stall)
		else $error("held result would be overwritten");
	a_meta_not_truncated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(meta_valid && truncated))
		else $error("truncated frame reported with extracted fields");
	a_direction_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direction |-> verdict == VERDICT_REVERSE)
		else $error("reverse direction without reverse verdict");
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !meta_valid |-> source_ip == '0 && src_mac == '0 && !direction)
		else $error("fields set without extracted metadata");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for ipv4_l4_header_classifier: Ethernet frames go in byte by
// byte under random idling on both channels, and every verdict is checked against a
// predictor kept in this file. Depends on hcls_pkg and the classifier RTL.
`default_nettype none

module tb;
	import hcls_pkg::*;

	localparam int CYCLE_LIMIT       = 600000;
	localparam int SETTLE_CYCLES     = 4;
	localparam int RANDOM_BYTES      = 250;
	localparam int MIN_RANDOM_FRAMES = 5;
	localparam int REPORT_LIMIT      = 10;
	localparam int MAC_AT            = 6;
	localparam int KIND_AT           = 12;
	localparam int PROTO_AT          = 23;
	localparam int PROTO_END         = 24;
	localparam int SRC_ADDR_AT       = 26;
	localparam int DST_ADDR_AT       = 30;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] frame_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] verdict;
	logic meta_valid;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [7:0] protocol;
	logic [7:0] tcp_flag_bits;
	logic [47:0] src_mac;
	logic direction;
	logic truncated;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ipv4_l4_header_classifier dut (.*);

	// Predictor copy of the configuration and of the per-frame parse state.
	logic [31:0] cfg_va = '0;
	logic [15:0] cfg_vp = '0;
	logic [31:0] cfg_oa = '0;
	int          fr_off = 0;
	logic [15:0] fr_kind = '0;
	logic [3:0]  fr_words = '0;
	logic [7:0]  fr_proto = '0;
	logic [31:0] fr_sip = '0;
	logic [31:0] fr_dip = '0;
	logic [15:0] fr_sport = '0;
	logic [15:0] fr_dport = '0;
	logic [7:0]  fr_flags = '0;
	logic [47:0] fr_mac = '0;

	hcls_result_t pending_verdicts[$];
	logic [7:0] frame_buf [0:255];
	int frame_len = 0;

	int cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int frames_sent = 0;
	int bytes_sent = 0;
	int settings_used = 1;
	int verdict_count [4] = '{0, 0, 0, 0};
	int truncated_count = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_hold = 0;
	int rx_free = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.", cycles,
				pending_verdicts.size());
			$display("** ipv4_l4_header_classifier: FAILED **");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int need_len(input int ihl, input logic [7:0] proto);
		int need;
		need = int'(IP_START) + 4 * ihl + int'((proto == PROTO_TCP) ? TCP_NEED : UDP_NEED);
		if (need < int'(ADDR_END))
			need = int'(ADDR_END);
		return need;
	endfunction

	task automatic classify_byte(input logic [7:0] b, input logic fin);
		int off;
		int l4;
		int len;
		int need;
		hcls_result_t r;
		off = fr_off;
		if (off == int'(IP_START))
			fr_words = b[3:0];
		l4 = int'(IP_START) + 4 * int'(fr_words);
		if (off >= MAC_AT && off < MAC_AT + 6)
			fr_mac = {fr_mac[39:0], b};
		if (off == KIND_AT || off == KIND_AT + 1)
			fr_kind = {fr_kind[7:0], b};
		if (off == PROTO_AT)
			fr_proto = b;
		if (off >= SRC_ADDR_AT && off < SRC_ADDR_AT + 4)
			fr_sip = {fr_sip[23:0], b};
		if (off >= DST_ADDR_AT && off < DST_ADDR_AT + 4)
			fr_dip = {fr_dip[23:0], b};
		if (off >= int'(IP_START)) begin
			if (off == l4 || off == l4 + 1)
				fr_sport = {fr_sport[7:0], b};
			if (off == l4 + 2 || off == l4 + 3)
				fr_dport = {fr_dport[7:0], b};
			if (off == l4 + int'(TCP_FLAGS_OFS))
				fr_flags = b;
		end
		if (!fin) begin
			if (fr_off < int'(OFFSET_MAX))
				fr_off++;
		end else begin
			r = '0;
			len = off + 1;
			if (len < int'(IP_START)) begin
				r.truncated = 1'b1;
			end else if (fr_kind == ETHERTYPE_ARP) begin
				r.verdict = VERDICT_ARP;
			end else if (fr_kind != ETHERTYPE_IPV4) begin
				r.verdict = VERDICT_DROP;
			end else if (len < PROTO_END) begin
				r.truncated = 1'b1;
			end else if (fr_proto == PROTO_TCP || fr_proto == PROTO_UDP) begin
				need = need_len(int'(fr_words), fr_proto);
				if (len < need) begin
					r.truncated = 1'b1;
				end else begin
					r.meta_valid = 1'b1;
					r.source_ip = fr_sip;
					r.dest_ip = fr_dip;
					r.source_port = fr_sport;
					r.dest_port = fr_dport;
					r.protocol = fr_proto;
					r.tcp_flag_bits = (fr_proto == PROTO_TCP) ? fr_flags : 8'h00;
					r.src_mac = fr_mac;
					if (fr_dip == cfg_va && fr_dport == cfg_vp) begin
						r.verdict = VERDICT_FORWARD;
					end else if (fr_dip == cfg_oa) begin
						r.verdict = VERDICT_REVERSE;
						r.direction = 1'b1;
					end
				end
			end
			pending_verdicts.push_back(r);
			fr_off = 0;
			fr_kind = '0;
			fr_words = '0;
			fr_proto = '0;
			fr_sip = '0;
			fr_dip = '0;
			fr_sport = '0;
			fr_dport = '0;
			fr_flags = '0;
			fr_mac = '0;
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("Mismatch on result %0d:%s", results_seen, what);
	endtask

	task automatic check_result();
		hcls_result_t want;
		string diff;
		results_seen++;
		if (pending_verdicts.size() == 0) begin
			note_mismatch(" result arrived with no frame pending");
		end else begin
			want = pending_verdicts.pop_front();
			verdict_count[want.verdict]++;
			if (want.truncated)
				truncated_count++;
			diff = "";
			if (verdict !== want.verdict)
				diff = {diff, $sformatf(" verdict exp %0d got %0d", want.verdict, verdict)};
			if (meta_valid !== want.meta_valid)
				diff = {diff, $sformatf(" meta_valid exp %0d got %0d", want.meta_valid,
					meta_valid)};
			if (source_ip !== want.source_ip)
				diff = {diff, $sformatf(" source_ip exp %h got %h", want.source_ip, source_ip)};
			if (dest_ip !== want.dest_ip)
				diff = {diff, $sformatf(" dest_ip exp %h got %h", want.dest_ip, dest_ip)};
			if (source_port !== want.source_port)
				diff = {diff, $sformatf(" source_port exp %h got %h", want.source_port,
					source_port)};
			if (dest_port !== want.dest_port)
				diff = {diff, $sformatf(" dest_port exp %h got %h", want.dest_port, dest_port)};
			if (protocol !== want.protocol)
				diff = {diff, $sformatf(" protocol exp %h got %h", want.protocol, protocol)};
			if (tcp_flag_bits !== want.tcp_flag_bits)
				diff = {diff, $sformatf(" tcp_flag_bits exp %h got %h", want.tcp_flag_bits,
					tcp_flag_bits)};
			if (src_mac !== want.src_mac)
				diff = {diff, $sformatf(" src_mac exp %h got %h", want.src_mac,
					src_mac)};
			if (direction !== want.direction)
				diff = {diff, $sformatf(" direction exp %0d got %0d", want.direction,
					direction)};
			if (truncated !== want.truncated)
				diff = {diff, $sformatf(" truncated exp %0d got %0d", want.truncated,
					truncated)};
			if (diff != "")
				note_mismatch(diff);
		end
	endtask

	// Result side: check every accepted transaction and stall in random bursts.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			check_result();
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else if (rx_calm || rx_free > 0) begin
			out_stall <= 1'b0;
			if (rx_free > 0)
				rx_free--;
		end else begin
			out_stall <= 1'b0;
			rx_free = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) :
				$urandom_range(0, 12);
			rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
				$urandom_range(1, 3);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		classify_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_len; i++)
			send_byte(frame_buf[i], i == frame_len - 1);
		frames_sent++;
	endtask

	// Builds a frame with the given header fields over random filler and sends it.
	task automatic transmit_frame(input logic [15:0] etype, input int ihl,
			input logic [7:0] proto, input logic [31:0] dip, input logic [15:0] dp,
			input int len);
		int i;
		int l4;
		logic [31:0] sip;
		logic [15:0] sp;
		logic [3:0] ver;
		sip = $urandom;
		sp = 16'($urandom);
		ver = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
		for (i = 0; i < 256; i++)
			frame_buf[i] = 8'($urandom);
		frame_buf[KIND_AT] = etype[15:8];
		frame_buf[KIND_AT + 1] = etype[7:0];
		frame_buf[IP_START] = {ver, 4'(ihl)};
		frame_buf[PROTO_AT] = proto;
		for (i = 0; i < 4; i++) begin
			frame_buf[SRC_ADDR_AT + i] = sip[31 - 8 * i -: 8];
			frame_buf[DST_ADDR_AT + i] = dip[31 - 8 * i -: 8];
		end
		if (ihl >= 5) begin
			l4 = int'(IP_START) + 4 * ihl;
			frame_buf[l4] = sp[15:8];
			frame_buf[l4 + 1] = sp[7:0];
			frame_buf[l4 + 2] = dp[15:8];
			frame_buf[l4 + 3] = dp[7:0];
		end
		frame_len = len;
		send_frame();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] va, input logic [15:0] vp,
			input logic [31:0] oa);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_UNUSED_INDEX;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_index <= CFG_VIRTUAL_ADDRESS;
		cfg_data <= va;
		@(posedge clk);
		cfg_index <= CFG_VIRTUAL_PORT;
		cfg_data <= {16'($urandom), vp};
		@(posedge clk);
		cfg_index <= CFG_OWN_ADDRESS;
		cfg_data <= oa;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_va = va;
		cfg_vp = vp;
		cfg_oa = oa;
		settings_used++;
	endtask

	task automatic test_reset_config();
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 54);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h0, 16'h1234, 42);
	endtask

	task automatic test_address_match();
		set_config(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 54);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFE, 54);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h0000_0000, 16'hFFFF, 38);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h7F00_0001, 16'hFFFF, 42);
		set_config(32'h0A00_0001, 16'h0050, 32'h0A00_0001);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0A00_0001, 16'h0050, 54);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0A00_0001, 16'h0051, 54);
		set_config(32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hFFFF_FFFF, 16'h0000, 42);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0000_0000, 16'h0000, 54);
	endtask

	task automatic test_ether_types();
		transmit_frame(ETHERTYPE_ARP, 5, PROTO_TCP, 32'h0, 16'h0, 20);
		transmit_frame(ETHERTYPE_ARP, 5, PROTO_TCP, 32'h0, 16'h0, 14);
		transmit_frame(ETHERTYPE_ARP, 5, PROTO_TCP, 32'h0, 16'h0, 5);
		transmit_frame(16'h86DD, 5, PROTO_TCP, 32'h0, 16'h0, 20);
		transmit_frame(ETHERTYPE_IPV4, 5, 8'd1, 32'h0, 16'h0, 30);
	endtask

	task automatic test_short_frames();
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 1);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 13);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 14);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 23);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 24);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h0, 16'h0, 33);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h0, 16'h0, 37);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h0, 16'h0, 38);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 47);
		transmit_frame(ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 16'h0, 48);
	endtask

	task automatic test_header_length();
		transmit_frame(ETHERTYPE_IPV4, 0, PROTO_TCP, 32'h0, 16'h0, 34);
		transmit_frame(ETHERTYPE_IPV4, 4, PROTO_UDP, 32'h0, 16'h0, 40);
		transmit_frame(ETHERTYPE_IPV4, 15, PROTO_TCP, 32'h0, 16'h0, 87);
		transmit_frame(ETHERTYPE_IPV4, 15, PROTO_TCP, 32'h0, 16'h0, 88);
		transmit_frame(ETHERTYPE_IPV4, 15, PROTO_UDP, 32'h0, 16'h0, 78);
	endtask

	task automatic test_long_frames();
		transmit_frame(ETHERTYPE_IPV4, 6, PROTO_TCP, 32'h0, 16'h0, 130);
	endtask

	task automatic test_random_traffic();
		int byte_start;
		int frame_start;
		int kind;
		int ihl;
		int len;
		int r;
		int i;
		logic [7:0] proto;
		logic [31:0] dip;
		logic [15:0] dp;
		logic [31:0] va;
		logic [31:0] oa;
		logic [15:0] vp;
		byte_start = bytes_sent;
		frame_start = frames_sent;
		while (bytes_sent - byte_start < RANDOM_BYTES ||
				frames_sent - frame_start < MIN_RANDOM_FRAMES) begin
			if ($urandom_range(0, 24) == 0) begin
				r = $urandom_range(0, 9);
				va = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
				r = $urandom_range(0, 9);
				vp = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
				r = $urandom_range(0, 9);
				oa = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? va :
					32'($urandom);
				set_config(va, vp, oa);
			end else if ($urandom_range(0, 29) == 0) begin
				wait_idle();
			end
			if ($urandom_range(0, 14) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 14) == 0)
				rx_calm = !rx_calm;

			r = $urandom_range(0, 99);
			ihl = (r < 80) ? 5 : (r < 92) ? $urandom_range(6, 15) : $urandom_range(0, 4);
			proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
			r = $urandom_range(0, 3);
			dip = (r == 0) ? cfg_va : (r == 1) ? cfg_oa : (r == 2) ? 32'($urandom) :
				cfg_va ^ (32'h1 << $urandom_range(0, 31));
			r = $urandom_range(0, 3);
			dp = (r < 2) ? cfg_vp : (r == 2) ? 16'($urandom) :
				cfg_vp ^ (16'h1 << $urandom_range(0, 15));
			kind = $urandom_range(0, 99);
			if (kind < 62) begin
				r = $urandom_range(0, 99);
				len = need_len(ihl, proto);
				if (r < 15)
					len = $urandom_range(1, len - 1);
				else if (r < 85)
					len = len + $urandom_range(0, 6);
				else if (r < 97)
					len = len + $urandom_range(7, 40);
				else
					len = $urandom_range(130, 200);
				transmit_frame(ETHERTYPE_IPV4, ihl, proto, dip, dp, len);
			end else if (kind < 72) begin
				transmit_frame(ETHERTYPE_ARP, ihl, proto, dip, dp, $urandom_range(1, 64));
			end else if (kind < 82) begin
				proto = 8'($urandom);
				if (proto == PROTO_TCP || proto == PROTO_UDP)
					proto = proto + 8'd1;
				transmit_frame(ETHERTYPE_IPV4, ihl, proto, dip, dp,
					$urandom_range(1, 64));
			end else if (kind < 90) begin
				r = $urandom_range(0, 2);
				transmit_frame((r == 0) ? 16'($urandom) :
					(r == 1) ? ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15)) :
					ETHERTYPE_ARP ^ (16'h1 << $urandom_range(0, 15)),
					ihl, proto, dip, dp, $urandom_range(1, 64));
			end else begin
				frame_len = $urandom_range(1, 80);
				for (i = 0; i < frame_len; i++)
					frame_buf[i] = 8'($urandom);
				send_frame();
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_config();
		test_address_match();
		test_ether_types();
		test_short_frames();
		test_header_length();
		test_long_frames();
		test_random_traffic();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d frames in %0d bytes under %0d register settings, %0d results.",
			frames_sent, bytes_sent, settings_used, results_seen);
		$display("Verdicts drop %0d, arp %0d, forward %0d, reverse %0d; truncated %0d.",
			verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
			truncated_count);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("** ipv4_l4_header_classifier: PASSED **");
		end else begin
			$display("Mismatches: %0d, results outstanding: %0d.", mismatches,
				pending_verdicts.size());
			$display("** ipv4_l4_header_classifier: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
